[rtl/ptb_pkg.sv]
`timescale 1ns / 1ps

package ptb_pkg;

  localparam int MAX_TEXT      = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_CAP      = MAX_TEXT + 2;
  localparam int EDGE_DEPTH    = NODE_CAP * ALPHABET_SIZE;

  localparam int NODE_W   = 11;
  localparam int LEN_W    = 12;
  localparam int SYM_W    = 5;
  localparam int TEXT_W   = $clog2(MAX_TEXT + 1);
  localparam int TEXT_AW  = $clog2(MAX_TEXT);
  localparam int EDGE_AW  = $clog2(EDGE_DEPTH);

  localparam logic signed [LEN_W-1:0] LEN_ODD_ROOT = -12'sd1;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_FINAL  = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FINAL     = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE,
    S_WRD, S_WNODE, S_WTXT,
    S_ERD, S_EDAT, S_ECHK,
    S_FRD, S_FDAT, S_FCHK,
    S_FIN_A, S_FIN_B, S_FIN_C,
    S_RDA, S_RDAT, S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] node_index;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0]       node;
    logic signed [LEN_W-1:0] pal_length;
    logic [NODE_W-1:0]       occurrences;
    logic [NODE_W-1:0]       suffix_link;
    logic [NODE_W-1:0]       suffix_depth;
    logic                    created;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic [NODE_W-1:0]       link;
    logic signed [LEN_W-1:0] len;
    logic [NODE_W-1:0]       depth;
    logic [NODE_W-1:0]       parent;
    logic [SYM_W-1:0]        sym;
  } node_t;

  function automatic logic [EDGE_AW-1:0] edge_addr(input logic [NODE_W-1:0] nd,
                                                   input logic [SYM_W-1:0] s);
    return EDGE_AW'(nd) * EDGE_AW'(ALPHABET_SIZE) + EDGE_AW'(s);
  endfunction

endpackage

[rtl/ptb_ram.sv]
`timescale 1ns / 1ps

module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/palindromic_tree_builder_core.sv]
// Palindromic tree (eertree) builder.
// Input channel in_valid/in_stall/in_data carries one command per transfer:
// append symbol, finalize counts, read node, clear tree. Every command gives
// exactly one result transfer on out_valid/out_stall/out_data.
// The block takes one command at a time. An append walks suffix links, each
// step reading node memory and then, if the index is in range, text memory;
// it then reads the edge memory, and on a miss walks again and creates a node.
// The walks are amortized constant per symbol. Finalize visits each non-root
// node from the newest down (node read, count read, count write-back).
// Edge entries are validated against the parent and symbol kept per node,
// so the edge memory needs no clearing; only the two roots are written.
// After reset the block writes the two roots, in S_INIT0 and S_INIT1, before
// in_stall drops. The result sits in an output register; while the receiver stalls,
// the next command is still taken and runs until its result is ready.
`timescale 1ns / 1ps

module palindromic_tree_builder_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ptb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ptb_pkg::out_t out_data
);

  localparam int NODE_BITS = $bits(ptb_pkg::node_t);

  ptb_pkg::state_e state, state_next;

  logic [ptb_pkg::TEXT_W-1:0] text_len;
  logic [ptb_pkg::NODE_W-1:0] node_total;
  logic [ptb_pkg::NODE_W-1:0] last_node;
  logic                       counts_final;
  logic                       init_reply;

  logic [ptb_pkg::NODE_W-1:0]       x, x_link, cur, cur_link, w2, e_reg;
  logic signed [ptb_pkg::LEN_W-1:0] x_len, cur_len;
  logic                             phase;
  logic [ptb_pkg::SYM_W-1:0]        sym_r;
  logic [ptb_pkg::NODE_W-1:0]       idx_r;
  logic [ptb_pkg::NODE_W-1:0]       fin_n, fin_f, fin_cn;
  ptb_pkg::out_t                    res;

  logic                         node_we;
  logic [ptb_pkg::NODE_W-1:0]   node_waddr, node_raddr;
  ptb_pkg::node_t               node_wdata, nd;
  logic [NODE_BITS-1:0]         node_rdata;
  logic                         cnt_we;
  logic [ptb_pkg::NODE_W-1:0]   cnt_waddr, cnt_raddr, cnt_wdata, cnt_rdata;
  logic                         edge_we;
  logic [ptb_pkg::EDGE_AW-1:0]  edge_waddr, edge_raddr;
  logic [ptb_pkg::NODE_W-1:0]   edge_wdata, edge_rdata;
  logic                         txt_we;
  logic [ptb_pkg::TEXT_AW-1:0]  txt_waddr, txt_raddr;
  logic [ptb_pkg::SYM_W-1:0]    txt_wdata, txt_rdata;

  logic [ptb_pkg::SYM_W-1:0]        sym_sat;
  logic signed [ptb_pkg::LEN_W:0]   widx;
  logic                             walk_done;
  logic signed [ptb_pkg::LEN_W-1:0] wlen;
  logic [ptb_pkg::NODE_W-1:0]       wlink;
  logic                             evalid, fvalid;
  logic [ptb_pkg::NODE_W-1:0]       f_fin, f_depth;
  logic                             slot_free, accept;

  assign nd = ptb_pkg::node_t'(node_rdata);

  ptb_ram #(.WIDTH(NODE_BITS), .DEPTH(ptb_pkg::NODE_CAP)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  ptb_ram #(.WIDTH(ptb_pkg::NODE_W), .DEPTH(ptb_pkg::NODE_CAP)) u_count_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  ptb_ram #(.WIDTH(ptb_pkg::NODE_W), .DEPTH(ptb_pkg::EDGE_DEPTH)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  ptb_ram #(.WIDTH(ptb_pkg::SYM_W), .DEPTH(ptb_pkg::MAX_TEXT)) u_text_ram (
    .clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
    .raddr(txt_raddr), .rdata(txt_rdata)
  );

  assign in_stall  = (state != ptb_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  assign sym_sat = (in_data.symbol >= ptb_pkg::SYM_W'(ptb_pkg::ALPHABET_SIZE)) ?
                   ptb_pkg::SYM_W'(ptb_pkg::ALPHABET_SIZE - 1) : in_data.symbol;

  assign widx = $signed({2'b00, text_len}) - $signed({nd.len[ptb_pkg::LEN_W-1], nd.len})
                - 13'sd1;

  assign wlen  = (state == ptb_pkg::S_WNODE) ? nd.len : x_len;
  assign wlink = (state == ptb_pkg::S_WNODE) ? nd.link : x_link;

  // edge entries are trusted only if the child records this parent and symbol
  assign evalid = (e_reg >= ptb_pkg::NODE_W'(2)) && (e_reg < node_total) &&
                  (nd.parent == cur) && (nd.sym == sym_r);
  assign fvalid = (e_reg >= ptb_pkg::NODE_W'(2)) && (e_reg < node_total) &&
                  (nd.parent == w2) && (nd.sym == sym_r);
  assign f_fin   = fvalid ? e_reg : '0;
  assign f_depth = fvalid ? nd.depth + ptb_pkg::NODE_W'(1) : ptb_pkg::NODE_W'(1);

  always_comb begin
    state_next = state;
    walk_done  = 1'b0;
    node_we    = 1'b0;
    node_waddr = node_total;
    node_wdata = '0;
    node_raddr = x;
    cnt_we     = 1'b0;
    cnt_waddr  = e_reg;
    cnt_wdata  = '0;
    cnt_raddr  = x;
    edge_we    = 1'b0;
    edge_waddr = ptb_pkg::edge_addr(cur, sym_r);
    edge_wdata = node_total;
    edge_raddr = ptb_pkg::edge_addr(cur, sym_r);
    txt_we     = 1'b0;
    txt_waddr  = text_len[ptb_pkg::TEXT_AW-1:0];
    txt_wdata  = sym_sat;
    txt_raddr  = widx[ptb_pkg::TEXT_AW-1:0];
    case (state)
      ptb_pkg::S_INIT0: begin
        node_we         = 1'b1;
        node_waddr      = '0;
        node_wdata.link = ptb_pkg::NODE_W'(1);
        cnt_we          = 1'b1;
        cnt_waddr       = '0;
        state_next      = ptb_pkg::S_INIT1;
      end
      ptb_pkg::S_INIT1: begin
        node_we        = 1'b1;
        node_waddr     = ptb_pkg::NODE_W'(1);
        node_wdata.len = ptb_pkg::LEN_ODD_ROOT;
        cnt_we         = 1'b1;
        cnt_waddr      = ptb_pkg::NODE_W'(1);
        state_next     = init_reply ? ptb_pkg::S_OUT : ptb_pkg::S_IDLE;
      end
      ptb_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            ptb_pkg::FN_APPEND: begin
              if (counts_final || text_len >= ptb_pkg::TEXT_W'(ptb_pkg::MAX_TEXT)) begin
                state_next = ptb_pkg::S_OUT;
              end else begin
                txt_we     = 1'b1;
                state_next = ptb_pkg::S_WRD;
              end
            end
            ptb_pkg::FN_FINAL: begin
              state_next = counts_final ? ptb_pkg::S_OUT : ptb_pkg::S_FIN_A;
            end
            ptb_pkg::FN_READ: begin
              state_next = (in_data.node_index >= node_total) ? ptb_pkg::S_OUT :
                           ptb_pkg::S_RDA;
            end
            default: state_next = ptb_pkg::S_INIT0;
          endcase
        end
      end
      ptb_pkg::S_WRD: begin
        node_raddr = x;
        state_next = ptb_pkg::S_WNODE;
      end
      ptb_pkg::S_WNODE: begin
        if (nd.len == ptb_pkg::LEN_ODD_ROOT) begin
          walk_done = 1'b1;
        end else if (widx < 0) begin
          state_next = ptb_pkg::S_WRD;
        end else begin
          state_next = ptb_pkg::S_WTXT;
        end
      end
      ptb_pkg::S_WTXT: begin
        if (txt_rdata == sym_r) begin
          walk_done = 1'b1;
        end else begin
          state_next = ptb_pkg::S_WRD;
        end
      end
      ptb_pkg::S_ERD: begin
        state_next = ptb_pkg::S_EDAT;
      end
      ptb_pkg::S_EDAT: begin
        node_raddr = edge_rdata;
        cnt_raddr  = edge_rdata;
        state_next = ptb_pkg::S_ECHK;
      end
      ptb_pkg::S_ECHK: begin
        if (evalid) begin
          cnt_we     = 1'b1;
          cnt_waddr  = e_reg;
          cnt_wdata  = cnt_rdata + ptb_pkg::NODE_W'(1);
          state_next = ptb_pkg::S_OUT;
        end else begin
          state_next = ptb_pkg::S_WRD;
        end
      end
      ptb_pkg::S_FRD: begin
        edge_raddr = ptb_pkg::edge_addr(w2, sym_r);
        state_next = ptb_pkg::S_FDAT;
      end
      ptb_pkg::S_FDAT: begin
        node_raddr = edge_rdata;
        state_next = ptb_pkg::S_FCHK;
      end
      ptb_pkg::S_FCHK: begin
        node_we           = 1'b1;
        node_waddr        = node_total;
        node_wdata.link   = f_fin;
        node_wdata.len    = cur_len + ptb_pkg::LEN_W'(2);
        node_wdata.depth  = f_depth;
        node_wdata.parent = cur;
        node_wdata.sym    = sym_r;
        cnt_we            = 1'b1;
        cnt_waddr         = node_total;
        cnt_wdata         = ptb_pkg::NODE_W'(1);
        edge_we           = 1'b1;
        state_next        = ptb_pkg::S_OUT;
      end
      ptb_pkg::S_FIN_A: begin
        node_raddr = fin_n;
        cnt_raddr  = fin_n;
        state_next = (fin_n < ptb_pkg::NODE_W'(2)) ? ptb_pkg::S_OUT : ptb_pkg::S_FIN_B;
      end
      ptb_pkg::S_FIN_B: begin
        cnt_raddr  = nd.link;
        state_next = ptb_pkg::S_FIN_C;
      end
      ptb_pkg::S_FIN_C: begin
        cnt_we     = 1'b1;
        cnt_waddr  = fin_f;
        cnt_wdata  = cnt_rdata + fin_cn;
        state_next = ptb_pkg::S_FIN_A;
      end
      ptb_pkg::S_RDA: begin
        node_raddr = idx_r;
        cnt_raddr  = idx_r;
        state_next = ptb_pkg::S_RDAT;
      end
      ptb_pkg::S_RDAT: begin
        state_next = ptb_pkg::S_OUT;
      end
      ptb_pkg::S_OUT: begin
        if (slot_free) begin
          state_next = ptb_pkg::S_IDLE;
        end
      end
      default: state_next = ptb_pkg::S_IDLE;
    endcase
    if (walk_done) begin
      state_next = phase ? ptb_pkg::S_FRD : ptb_pkg::S_ERD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptb_pkg::S_INIT0;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_len     <= '0;
      node_total   <= ptb_pkg::NODE_W'(2);
      last_node    <= '0;
      counts_final <= 1'b0;
      init_reply   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ptb_pkg::S_OUT && slot_free) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ptb_pkg::S_INIT1: begin
          init_reply <= 1'b0;
        end
        ptb_pkg::S_IDLE: begin
          if (accept) begin
            sym_r <= sym_sat;
            idx_r <= in_data.node_index;
            x     <= last_node;
            phase <= 1'b0;
            res   <= '0;
            fin_n <= node_total - ptb_pkg::NODE_W'(1);
            case (in_data.func)
              ptb_pkg::FN_APPEND: begin
                if (counts_final) begin
                  res.status <= ptb_pkg::ST_FINAL;
                end else if (text_len >= ptb_pkg::TEXT_W'(ptb_pkg::MAX_TEXT)) begin
                  res.status <= ptb_pkg::ST_FULL;
                end
              end
              ptb_pkg::FN_FINAL: begin
                if (counts_final) begin
                  res.status <= ptb_pkg::ST_FINAL;
                end
              end
              ptb_pkg::FN_READ: begin
                if (in_data.node_index >= node_total) begin
                  res.status <= ptb_pkg::ST_BAD_INDEX;
                end
              end
              default: begin
                text_len     <= '0;
                node_total   <= ptb_pkg::NODE_W'(2);
                last_node    <= '0;
                counts_final <= 1'b0;
                init_reply   <= 1'b1;
              end
            endcase
          end
        end
        ptb_pkg::S_WNODE: begin
          x_len  <= nd.len;
          x_link <= nd.link;
          if (!walk_done && widx < 0) begin
            x <= nd.link;
          end
        end
        ptb_pkg::S_WTXT: begin
          if (!walk_done) begin
            x <= x_link;
          end
        end
        ptb_pkg::S_EDAT, ptb_pkg::S_FDAT: begin
          e_reg <= edge_rdata;
        end
        ptb_pkg::S_ECHK: begin
          if (evalid) begin
            last_node        <= e_reg;
            text_len         <= text_len + ptb_pkg::TEXT_W'(1);
            res.node         <= e_reg;
            res.pal_length   <= nd.len;
            res.occurrences  <= cnt_rdata + ptb_pkg::NODE_W'(1);
            res.suffix_link  <= nd.link;
            res.suffix_depth <= nd.depth;
          end else begin
            phase <= 1'b1;
            x     <= cur_link;
          end
        end
        ptb_pkg::S_FCHK: begin
          node_total       <= node_total + ptb_pkg::NODE_W'(1);
          last_node        <= node_total;
          text_len         <= text_len + ptb_pkg::TEXT_W'(1);
          res.node         <= node_total;
          res.pal_length   <= cur_len + ptb_pkg::LEN_W'(2);
          res.occurrences  <= ptb_pkg::NODE_W'(1);
          res.suffix_link  <= f_fin;
          res.suffix_depth <= f_depth;
          res.created      <= 1'b1;
        end
        ptb_pkg::S_FIN_A: begin
          if (fin_n < ptb_pkg::NODE_W'(2)) begin
            counts_final <= 1'b1;
          end
        end
        ptb_pkg::S_FIN_B: begin
          fin_f  <= nd.link;
          fin_cn <= cnt_rdata;
        end
        ptb_pkg::S_FIN_C: begin
          fin_n <= fin_n - ptb_pkg::NODE_W'(1);
        end
        ptb_pkg::S_RDAT: begin
          res.node         <= idx_r;
          res.pal_length   <= nd.len;
          res.occurrences  <= cnt_rdata;
          res.suffix_link  <= nd.link;
          res.suffix_depth <= nd.depth;
        end
        default: ;
      endcase
      if (walk_done) begin
        if (phase) begin
          w2 <= x;
        end else begin
          cur      <= x;
          cur_len  <= wlen;
          cur_link <= wlink;
        end
      end
    end
  end

  a_node_total_range: assert property (@(posedge clk) disable iff (rst)
    node_total >= ptb_pkg::NODE_W'(2) &&
    node_total <= ptb_pkg::NODE_W'(ptb_pkg::NODE_CAP))
    else $error("node_total out of range");

  a_text_len_range: assert property (@(posedge clk) disable iff (rst)
    text_len <= ptb_pkg::TEXT_W'(ptb_pkg::MAX_TEXT))
    else $error("text_len beyond capacity");

  a_create_bumps_total: assert property (@(posedge clk) disable iff (rst)
    state == ptb_pkg::S_FCHK |=> node_total == $past(node_total) + ptb_pkg::NODE_W'(1))
    else $error("node creation did not advance node_total");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ptb_pkg::S_IDLE)
    else $error("accepted transfer left block idle");

  a_final_only_from_finalize: assert property (@(posedge clk) disable iff (rst)
    $rose(counts_final) |-> $past(state) == ptb_pkg::S_FIN_A)
    else $error("counts_final set outside finalize");

endmodule

[test/palindromic_tree_builder_core_test.sv]
`timescale 1ns / 1ps

module palindromic_tree_builder_core_test;
  import ptb_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct {
    in_t  cmd;
    bit   fixed;
    out_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  palindromic_tree_builder_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // tree mirror
  logic [SYM_W-1:0] txt [0:MAX_TEXT-1];
  int edges [0:EDGE_DEPTH-1];
  int link_of [0:NODE_CAP-1];
  int len_of [0:NODE_CAP-1];
  int cnt_of [0:NODE_CAP-1];
  int depth_of [0:NODE_CAP-1];
  int text_len, node_cnt, last_nd;
  bit counts_done;

  out_t result_q[$];
  int   errors = 0;
  int   cycles = 0;
  int   issued = 0;
  bit   long_hold = 0;
  bit   quiet = 0;
  dir_row_t dir_tab[$];

  function automatic void tree_clear();
    for (int i = 0; i < EDGE_DEPTH; i++) edges[i] = 0;
    for (int i = 0; i < NODE_CAP; i++) begin
      link_of[i] = 0; len_of[i] = 0; cnt_of[i] = 0; depth_of[i] = 0;
    end
    for (int i = 0; i < MAX_TEXT; i++) txt[i] = '0;
    link_of[0] = 1;
    len_of[1] = -1;
    text_len = 0;
    node_cnt = 2;
    last_nd = 0;
    counts_done = 0;
  endfunction

  function automatic int walk_links(int start, int pos, int sym);
    int x;
    int steps;
    int idx;
    x = start;
    steps = 0;
    while (steps <= node_cnt + 1) begin
      if (x >= NODE_CAP) return 1;
      if (len_of[x] == -1) return x;
      idx = pos - len_of[x] - 1;
      if (idx >= 0 && idx < MAX_TEXT && txt[idx] == sym) return x;
      x = link_of[x];
      steps++;
    end
    return 1;
  endfunction

  function automatic out_t node_view(int nd, bit created);
    out_t r;
    r = '0;
    r.node = nd;
    r.pal_length = len_of[nd];
    r.occurrences = cnt_of[nd];
    r.suffix_link = link_of[nd];
    r.suffix_depth = depth_of[nd];
    r.created = created;
    r.status = ST_OK;
    return r;
  endfunction

  function automatic out_t tree_step(in_t c);
    out_t r;
    int sym, pos, cur, nw, f;
    bit made;
    r = '0;
    case (func_e'(c.func))
      FN_APPEND: begin
        if (counts_done) r.status = ST_FINAL;
        else if (text_len >= MAX_TEXT) r.status = ST_FULL;
        else begin
          sym = c.symbol;
          if (sym >= ALPHABET_SIZE) sym = ALPHABET_SIZE - 1;
          pos = text_len;
          txt[pos] = sym;
          cur = walk_links(last_nd, pos, sym);
          made = 0;
          if (edges[cur * ALPHABET_SIZE + sym] == 0 && node_cnt < NODE_CAP) begin
            nw = node_cnt;
            len_of[nw] = len_of[cur] + 2;
            f = edges[walk_links(link_of[cur], pos, sym) * ALPHABET_SIZE + sym];
            link_of[nw] = f;
            cnt_of[nw] = 0;
            depth_of[nw] = (depth_of[f] + 1) & 'h7ff;
            for (int k = 0; k < ALPHABET_SIZE; k++) edges[nw * ALPHABET_SIZE + k] = 0;
            edges[cur * ALPHABET_SIZE + sym] = nw;
            node_cnt++;
            made = 1;
          end
          text_len = pos + 1;
          last_nd = edges[cur * ALPHABET_SIZE + sym];
          cnt_of[last_nd] = (cnt_of[last_nd] + 1) & 'h7ff;
          r = node_view(last_nd, made);
        end
      end
      FN_FINAL: begin
        if (counts_done) r.status = ST_FINAL;
        else begin
          for (int i = node_cnt - 1; i >= 2; i--) begin
            f = link_of[i];
            if (f < NODE_CAP) cnt_of[f] = (cnt_of[f] + cnt_of[i]) & 'h7ff;
          end
          counts_done = 1;
        end
      end
      FN_READ: begin
        if (c.node_index >= node_cnt || c.node_index >= NODE_CAP) r.status = ST_BAD_INDEX;
        else r = node_view(c.node_index, 0);
      end
      default: tree_clear();
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  task automatic check_result(out_t got);
    out_t w;
    if (result_q.size() == 0) begin
      report("unexpected transfer, node", got.node, -1);
      return;
    end
    w = result_q.pop_front();
    if (got.node !== w.node) report("node", got.node, w.node);
    if (got.pal_length !== w.pal_length) report("pal_length", got.pal_length, w.pal_length);
    if (got.occurrences !== w.occurrences) report("occurrences", got.occurrences, w.occurrences);
    if (got.suffix_link !== w.suffix_link) report("suffix_link", got.suffix_link, w.suffix_link);
    if (got.suffix_depth !== w.suffix_depth)
      report("suffix_depth", got.suffix_depth, w.suffix_depth);
    if (got.created !== w.created) report("created", got.created, w.created);
    if (got.status !== w.status) report("status", got.status, w.status);
  endtask

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(in_t c, bit fixed = 0, out_t want = '0);
    out_t pred;
    int gap;
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = tree_step(c);
    result_q.push_back(fixed ? want : pred);
    issued++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_t mk(func_e f, int sym = 0, int idx = 0);
    in_t c;
    c.func = f;
    c.symbol = sym;
    c.node_index = idx;
    return c;
  endfunction

  function automatic void row(func_e f, int sym = 0, int idx = 0);
    dir_tab.push_back('{mk(f, sym, idx), 1'b0, out_t'('0)});
  endfunction

  function automatic void row_fixed(func_e f, int sym, int idx, out_t want);
    dir_tab.push_back('{mk(f, sym, idx), 1'b1, want});
  endfunction

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  function automatic int read_index();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, node_cnt + 1);
    return $urandom_range(0, 2047);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("palindromic_tree_builder_core_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result(out_data);
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 299) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  initial begin
    int n, alpha, base, seg, target;
    bit full_done;
    in_t c;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    tree_clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    row_fixed(FN_READ, 0, 0, '{11'd0, 12'sd0, 11'd0, 11'd1, 11'd0, 1'b0, ST_OK});
    row_fixed(FN_READ, 0, 1, '{11'd1, -12'sd1, 11'd0, 11'd0, 11'd0, 1'b0, ST_OK});
    row_fixed(FN_READ, 0, 2, '{11'd0, 12'sd0, 11'd0, 11'd0, 11'd0, 1'b0, ST_BAD_INDEX});
    row_fixed(FN_APPEND, 0, 0, '{11'd2, 12'sd1, 11'd1, 11'd0, 11'd1, 1'b1, ST_OK});
    row(FN_APPEND, 31);
    row(FN_APPEND, 0);
    row(FN_APPEND, 25);
    row(FN_APPEND, 0);
    row(FN_APPEND, 0);
    row(FN_APPEND, 16, 2047);
    row(FN_APPEND, 0);
    row(FN_READ, 0, 2);
    row(FN_READ, 0, 4);
    row(FN_FINAL);
    row(FN_READ, 0, 2);
    row(FN_READ, 0, 3);
    row_fixed(FN_APPEND, 1, 0, '{11'd0, 12'sd0, 11'd0, 11'd0, 11'd0, 1'b0, ST_FINAL});
    row_fixed(FN_FINAL, 0, 0, '{11'd0, 12'sd0, 11'd0, 11'd0, 11'd0, 1'b0, ST_FINAL});
    row_fixed(FN_READ, 0, 2047,
              '{11'd0, 12'sd0, 11'd0, 11'd0, 11'd0, 1'b0, ST_BAD_INDEX});
    row_fixed(FN_CLEAR, 0, 0, '{11'd0, 12'sd0, 11'd0, 11'd0, 11'd0, 1'b0, ST_OK});
    row_fixed(FN_READ, 0, 1, '{11'd1, -12'sd1, 11'd0, 11'd0, 11'd0, 1'b0, ST_OK});
    row_fixed(FN_READ, 0, 2, '{11'd0, 12'sd0, 11'd0, 11'd0, 11'd0, 1'b0, ST_BAD_INDEX});
    foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].fixed, dir_tab[i].want);

    full_done = 0;
    seg = 0;
    target = issued + RANDOM_ITEMS;
    while (issued < target) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 3 || seg == 5) wait_drain();
      if (seg == 2) long_hold = 1;
      send_cmd(mk(FN_CLEAR, $urandom_range(0, 31), $urandom_range(0, 2047)));
      if (seg == 3 && !full_done) begin
        n = MAX_TEXT + 6;
        full_done = 1;
      end else begin
        n = $urandom_range(3, 60);
      end
      alpha = $urandom_range(1, 4);
      base = $urandom_range(0, ALPHABET_SIZE - alpha);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 2) begin
          send_cmd(mk(FN_READ, $urandom_range(0, 31), read_index()));
        end else begin
          c = mk(FN_APPEND, base + $urandom_range(0, alpha - 1), $urandom_range(0, 2047));
          if ($urandom_range(0, 9) == 0) c.symbol = $urandom_range(0, 31);
          send_cmd(c);
        end
      end
      if ($urandom_range(0, 9) < 7) begin
        send_cmd(mk(FN_FINAL, $urandom_range(0, 31), $urandom_range(0, 2047)));
        for (int i = $urandom_range(1, 8); i > 0; i--)
          send_cmd(mk(FN_READ, 0, read_index()));
      end
      if ($urandom_range(0, 9) == 0) begin
        c.func = $urandom_range(0, 2);
        c.symbol = $urandom_range(0, 31);
        c.node_index = $urandom_range(0, 2047);
        send_cmd(c);
      end
      seg++;
    end

    in_valid <= 1'b0;
    quiet = 0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("palindromic_tree_builder_core_test: done, clean");
    else $display("palindromic_tree_builder_core_test: done, errors");
    $finish;
  end

endmodule

[files.f]
rtl/ptb_pkg.sv
rtl/ptb_ram.sv
rtl/palindromic_tree_builder_core.sv
test/palindromic_tree_builder_core_test.sv
